// File: hw/rtl/scrt_pkg.sv
// Shared types, constants and the CRC-8 byte function for the scratchpad
// temperature checker. No dependencies; used by every RTL file of the block.
`default_nettype none

package scrt_pkg;

  // Reflected CRC-8 polynomial and power-on scratchpad reading
  localparam logic [7:0] CRC_POLY     = 8'h8C;
  localparam logic [7:0] POWERON_LOW  = 8'h50;
  localparam logic [7:0] POWERON_HIGH = 8'h05;

  // Byte positions within a frame
  localparam logic [3:0] POS_LOW       = 4'd0;
  localparam logic [3:0] POS_HIGH      = 4'd1;
  localparam logic [3:0] LAST_DATA_POS = 4'd8;
  localparam logic [3:0] IDLE_POS      = 4'd9;

  // Default failure threshold on consecutive bad reads
  localparam int ERROR_LIMIT_DEF = 5;

  // Configuration register indexes
  localparam logic [2:0] CFG_SENSOR_ENABLE = 3'd0;
  localparam logic [2:0] CFG_HIGH_LIMIT    = 3'd1;
  localparam logic [2:0] CFG_LOW_LIMIT     = 3'd2;
  localparam logic [2:0] CFG_HYSTERESIS    = 3'd3;
  localparam logic [2:0] CFG_CALIBRATION   = 3'd4;

  // Configuration reset values
  localparam logic              RST_SENSOR_ENABLE = 1'b1;
  localparam logic signed [7:0] RST_HIGH_LIMIT    = 8'sd127;
  localparam logic signed [7:0] RST_LOW_LIMIT     = -8'sd128;
  localparam logic [7:0]        RST_HYSTERESIS    = 8'd1;
  localparam logic signed [14:0] RST_CALIBRATION  = 15'sd0;

  // Alarm modes
  localparam logic [1:0] MODE_NORMAL = 2'd0;
  localparam logic [1:0] MODE_HIGH   = 2'd1;
  localparam logic [1:0] MODE_LOW    = 2'd2;

  // Alarm events
  localparam logic [1:0] EV_NONE     = 2'd0;
  localparam logic [1:0] EV_HIGH     = 2'd1;
  localparam logic [1:0] EV_LOW      = 2'd2;
  localparam logic [1:0] EV_FAILURE  = 2'd3;

  // Whole degrees to hundredths
  localparam logic signed [19:0] CENTI_PER_DEG = 20'sd100;

  // Check beat from the frame tracker to the evaluator
  typedef struct packed {
    logic               match;
    logic signed [18:0] centi_raw;
  } check_t;

  // Alarm and calibration settings seen by the evaluator
  typedef struct packed {
    logic signed [7:0]  high_limit;
    logic signed [7:0]  low_limit;
    logic [7:0]         hysteresis;
    logic signed [14:0] calibration;
  } alarm_cfg_t;

  // One byte through the reflected CRC-8, LSB first
  function automatic logic [7:0] crc8_byte(input logic [7:0] crc_in, input logic [7:0] b);
    logic [7:0] c;
    logic       fb;
    c = crc_in;
    for (int i = 0; i < 8; i++) begin
      fb = c[0] ^ b[i];
      c  = {1'b0, c[7:1]};
      if (fb) begin
        c = c ^ CRC_POLY;
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/scrt_frame.sv
// Frame tracker: byte position, running CRC, reading capture and the
// registered check beat with the converted raw temperature. Uses scrt_pkg.
`default_nettype none

module scrt_frame (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  in_valid,
  output logic                 in_ready,
  input  wire  [7:0]           in_data_byte,
  input  wire                  in_frame_start,
  input  wire                  sensor_enable,
  output logic                 chk_valid,
  input  wire                  chk_ready,
  output scrt_pkg::check_t     chk
);

  logic [3:0]       pos_r, pos_nxt;
  logic [7:0]       crc_r, crc_nxt;
  logic [7:0]       rd_low_r, rd_low_nxt;
  logic [7:0]       rd_high_r, rd_high_nxt;
  logic             chk_valid_r, chk_valid_nxt;
  scrt_pkg::check_t chk_r, chk_nxt;

  logic       in_fire;
  logic [3:0] pos_eff;
  logic [7:0] crc_eff;
  logic [7:0] crc_adj;
  logic [15:0] raw;
  logic        neg;
  logic [16:0] mag;
  logic [17:0] scaled;

  assign in_ready  = !chk_valid_r || chk_ready;
  assign in_fire   = in_valid && in_ready;
  assign chk_valid = chk_valid_r;
  assign chk       = chk_r;

  // Frame start restarts position and CRC
  assign pos_eff = in_frame_start ? scrt_pkg::POS_LOW : pos_r;
  assign crc_eff = in_frame_start ? 8'd0 : crc_r;

  // Power-on reading forces a CRC mismatch
  assign crc_adj = (rd_low_r == scrt_pkg::POWERON_LOW && rd_high_r == scrt_pkg::POWERON_HIGH) ?
                   crc_r + 8'd1 : crc_r;

  // Sign-magnitude conversion: 6*m + floor(m/4) hundredths
  assign raw    = {rd_high_r, rd_low_r};
  assign neg    = raw[15];
  assign mag    = neg ? ({1'b0, ~raw} + 17'd1) : {1'b0, raw};
  assign scaled = {mag, 1'b0} + {mag[15:0], 2'b00} + {3'b000, mag[16:2]};

  // Byte tracking and check beat generation
  always_comb begin
    pos_nxt       = pos_r;
    crc_nxt       = crc_r;
    rd_low_nxt    = rd_low_r;
    rd_high_nxt   = rd_high_r;
    chk_valid_nxt = chk_valid_r && !chk_ready;
    chk_nxt       = chk_r;
    if (in_fire) begin
      if (pos_eff < scrt_pkg::LAST_DATA_POS) begin
        if (pos_eff == scrt_pkg::POS_LOW) begin
          rd_low_nxt = in_data_byte;
        end else if (pos_eff == scrt_pkg::POS_HIGH) begin
          rd_high_nxt = in_data_byte;
        end
        crc_nxt = scrt_pkg::crc8_byte(crc_eff, in_data_byte);
        pos_nxt = pos_eff + 4'd1;
      end else if (pos_eff == scrt_pkg::LAST_DATA_POS) begin
        pos_nxt = scrt_pkg::IDLE_POS;
        if (sensor_enable) begin
          chk_valid_nxt     = 1'b1;
          chk_nxt.match     = (crc_adj == in_data_byte);
          chk_nxt.centi_raw = neg ? -$signed({1'b0, scaled}) : $signed({1'b0, scaled});
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= scrt_pkg::POS_LOW;
      crc_r       <= 8'd0;
      rd_low_r    <= 8'd0;
      rd_high_r   <= 8'd0;
      chk_valid_r <= 1'b0;
    end else begin
      pos_r       <= pos_nxt;
      crc_r       <= crc_nxt;
      rd_low_r    <= rd_low_nxt;
      rd_high_r   <= rd_high_nxt;
      chk_valid_r <= chk_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    chk_r <= chk_nxt;
  end

endmodule

`default_nettype wire

// File: hw/rtl/scrt_eval.sv
// Evaluator: calibration, error count, hysteresis alarm and the result
// register toward the output channel. Uses scrt_pkg.
`default_nettype none

module scrt_eval #(
  parameter int ERROR_LIMIT = scrt_pkg::ERROR_LIMIT_DEF
) (
  input  wire                    clk,
  input  wire                    rst_n,
  input  wire                    chk_valid,
  output logic                   chk_ready,
  input  wire scrt_pkg::check_t     chk,
  input  wire scrt_pkg::alarm_cfg_t cfg,
  output logic                   out_valid,
  input  wire                    out_ready,
  output logic signed [18:0]     out_temperature_centi,
  output logic                   out_read_ok,
  output logic [1:0]             out_alarm_event,
  output logic [1:0]             out_alarm_level,
  output logic [2:0]             out_error_count
);

  localparam logic [2:0] ERR_LIM = 3'(ERROR_LIMIT);

  logic               out_valid_r, out_valid_nxt;
  logic signed [18:0] last_temp_r, last_temp_nxt;
  logic [2:0]         cnt_r, cnt_nxt;
  logic [1:0]         mode_r, mode_nxt;
  logic               ok_r, ok_nxt;
  logic [1:0]         ev_r, ev_nxt;

  logic               chk_fire;
  logic signed [18:0] temp;
  logic signed [19:0] temp_w;
  logic signed [10:0] hi_up, hi_dn, lo_up, lo_dn;
  logic signed [19:0] hi_up_c, hi_dn_c, lo_up_c, lo_dn_c;
  logic [2:0]         cnt_inc;

  assign chk_ready = !out_valid_r || out_ready;
  assign chk_fire  = chk_valid && chk_ready;

  // Calibrated temperature
  assign temp   = chk.centi_raw + 19'(cfg.calibration);
  assign temp_w = 20'(temp);

  // Thresholds in hundredths
  assign hi_up   = 11'(cfg.high_limit) + $signed({3'b000, cfg.hysteresis});
  assign hi_dn   = 11'(cfg.high_limit) - $signed({3'b000, cfg.hysteresis});
  assign lo_up   = 11'(cfg.low_limit) + $signed({3'b000, cfg.hysteresis});
  assign lo_dn   = 11'(cfg.low_limit) - $signed({3'b000, cfg.hysteresis});
  assign hi_up_c = 20'(hi_up) * scrt_pkg::CENTI_PER_DEG;
  assign hi_dn_c = 20'(hi_dn) * scrt_pkg::CENTI_PER_DEG;
  assign lo_up_c = 20'(lo_up) * scrt_pkg::CENTI_PER_DEG;
  assign lo_dn_c = 20'(lo_dn) * scrt_pkg::CENTI_PER_DEG;

  // Saturating bad-read count before the failure jump
  assign cnt_inc = (cnt_r < ERR_LIM) ? cnt_r + 3'd1 : cnt_r;

  // Result and alarm state update on a check beat
  always_comb begin
    out_valid_nxt = out_valid_r && !out_ready;
    last_temp_nxt = last_temp_r;
    cnt_nxt       = cnt_r;
    mode_nxt      = mode_r;
    ok_nxt        = ok_r;
    ev_nxt        = ev_r;
    if (chk_fire) begin
      out_valid_nxt = 1'b1;
      ok_nxt        = chk.match;
      ev_nxt        = scrt_pkg::EV_NONE;
      if (chk.match) begin
        last_temp_nxt = temp;
        cnt_nxt       = 3'd0;
        case (mode_r)
          scrt_pkg::MODE_NORMAL: begin
            if (temp_w >= hi_up_c) begin
              ev_nxt   = scrt_pkg::EV_HIGH;
              mode_nxt = scrt_pkg::MODE_HIGH;
            end else if (temp_w <= lo_dn_c) begin
              ev_nxt   = scrt_pkg::EV_LOW;
              mode_nxt = scrt_pkg::MODE_LOW;
            end
          end
          scrt_pkg::MODE_HIGH: begin
            if (temp_w <= hi_dn_c) begin
              mode_nxt = scrt_pkg::MODE_NORMAL;
            end
          end
          scrt_pkg::MODE_LOW: begin
            if (temp_w >= lo_up_c) begin
              mode_nxt = scrt_pkg::MODE_NORMAL;
            end
          end
          default: mode_nxt = mode_r;
        endcase
      end else begin
        cnt_nxt = cnt_inc;
        if (cnt_inc == ERR_LIM) begin
          ev_nxt  = scrt_pkg::EV_FAILURE;
          cnt_nxt = cnt_inc + 3'd2;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      last_temp_r <= 19'sd0;
      cnt_r       <= 3'd0;
      mode_r      <= scrt_pkg::MODE_NORMAL;
    end else begin
      out_valid_r <= out_valid_nxt;
      last_temp_r <= last_temp_nxt;
      cnt_r       <= cnt_nxt;
      mode_r      <= mode_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ok_r <= ok_nxt;
    ev_r <= ev_nxt;
  end

  assign out_valid             = out_valid_r;
  assign out_temperature_centi = last_temp_r;
  assign out_read_ok           = ok_r;
  assign out_alarm_event       = ev_r;
  assign out_alarm_level       = mode_r;
  assign out_error_count       = cnt_r;

endmodule

`default_nettype wire

// File: hw/rtl/scratchpad_temp_check_alarm_core.sv
// Top level of the scratchpad temperature checker: configuration registers,
// frame tracker and evaluator. Uses scrt_pkg, scrt_frame and scrt_eval.
// Throughput: one byte per cycle; the input stalls only while a check beat and
// a result beat both wait on out_ready.
// Result path: after the edge that accepts byte 8, out_valid rises via the
// frame tracker check register, then the evaluator result register.
// Reset: synchronous, active low; clears position, CRC, readings, error count,
// alarm mode, last temperature and loads the configuration defaults.
`default_nettype none

module scratchpad_temp_check_alarm_core #(
  parameter int ERROR_LIMIT = scrt_pkg::ERROR_LIMIT_DEF
) (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                in_valid,
  output logic               in_ready,
  input  wire  [7:0]         in_data_byte,
  input  wire                in_frame_start,
  output logic               out_valid,
  input  wire                out_ready,
  output logic signed [18:0] out_temperature_centi,
  output logic               out_read_ok,
  output logic [1:0]         out_alarm_event,
  output logic [1:0]         out_alarm_level,
  output logic [2:0]         out_error_count,
  input  wire                cfg_valid,
  output logic               cfg_ready,
  input  wire  [2:0]         cfg_index,
  input  wire  [14:0]        cfg_data
);

  logic                 enable_r;
  scrt_pkg::alarm_cfg_t acfg_r;
  logic                 chk_valid;
  logic                 chk_ready;
  scrt_pkg::check_t     chk;

  assign cfg_ready = 1'b1;

  // Configuration register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r           <= scrt_pkg::RST_SENSOR_ENABLE;
      acfg_r.high_limit  <= scrt_pkg::RST_HIGH_LIMIT;
      acfg_r.low_limit   <= scrt_pkg::RST_LOW_LIMIT;
      acfg_r.hysteresis  <= scrt_pkg::RST_HYSTERESIS;
      acfg_r.calibration <= scrt_pkg::RST_CALIBRATION;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        scrt_pkg::CFG_SENSOR_ENABLE: enable_r           <= cfg_data[0];
        scrt_pkg::CFG_HIGH_LIMIT:    acfg_r.high_limit  <= $signed(cfg_data[7:0]);
        scrt_pkg::CFG_LOW_LIMIT:     acfg_r.low_limit   <= $signed(cfg_data[7:0]);
        scrt_pkg::CFG_HYSTERESIS:    acfg_r.hysteresis  <= cfg_data[7:0];
        scrt_pkg::CFG_CALIBRATION:   acfg_r.calibration <= $signed(cfg_data);
        default: ;
      endcase
    end
  end

  scrt_frame u_frame (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_data_byte   (in_data_byte),
    .in_frame_start (in_frame_start),
    .sensor_enable  (enable_r),
    .chk_valid      (chk_valid),
    .chk_ready      (chk_ready),
    .chk            (chk)
  );

  scrt_eval #(
    .ERROR_LIMIT (ERROR_LIMIT)
  ) u_eval (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .chk_valid             (chk_valid),
    .chk_ready             (chk_ready),
    .chk                   (chk),
    .cfg                   (acfg_r),
    .out_valid             (out_valid),
    .out_ready             (out_ready),
    .out_temperature_centi (out_temperature_centi),
    .out_read_ok           (out_read_ok),
    .out_alarm_event       (out_alarm_event),
    .out_alarm_level       (out_alarm_level),
    .out_error_count       (out_error_count)
  );

  // A good read always clears the error count
  a_ok_clears_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_read_ok) |-> (out_error_count == 3'd0))
    else $error("good read with nonzero error count");

  // A raised alarm leaves the matching alarm level
  a_event_level: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_alarm_event == scrt_pkg::EV_HIGH || out_alarm_event == scrt_pkg::EV_LOW))
    |-> (out_alarm_level == out_alarm_event && out_read_ok))
    else $error("alarm event does not match alarm level");

  // Failure is reported only on a rejected frame, with the count past the limit
  a_failure: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_alarm_event == scrt_pkg::EV_FAILURE)
    |-> (!out_read_ok && out_error_count == 3'(ERROR_LIMIT + 2)))
    else $error("failure report on bad state");

  // The count only holds values up to the limit or the reported mark
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_error_count <= 3'(ERROR_LIMIT) ||
                   out_error_count == 3'(ERROR_LIMIT + 2)))
    else $error("error count out of range");

  // No result beat right after reset
  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

`default_nettype wire
